@@ rtl/core/mpp_pkg.sv @@
// shared types and constants for the multicolor pixel packer
package mpp_pkg;

	localparam int PIXEL_W            = 8;
	localparam int PIXEL_BITS_DEFAULT = 8;
	localparam int NUM_SLOTS          = 4;
	localparam int SLOT_W             = 2;
	localparam int CNT_W              = 2;

	localparam logic       STATUS_DATA     = 1'b0;
	localparam logic       STATUS_OVERFLOW = 1'b1;
	localparam logic [7:0] PAD_BYTE        = 8'h00;

	typedef struct packed {
		logic [2:0] colors_used;
		logic [5:0] partial_byte;
		logic [1:0] pixel_position;
		logic       overflow_error;
	} state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       status;
		logic       last;
	} result_t;

endpackage

@@ rtl/core/multicolor_pixel_packer.sv @@
// multicolor pixel packer top level: input stage, color state and result buffer
// Accepts one pixel request per cycle unless stalled, and packs four 2-bit color codes per
// byte, first pixel in bits 7:6, assigning codes by first appearance of up to four colors;
// a request is registered in the input stage and its bytes in the result buffer. The output
// port gives one byte per cycle while out_ready is high; a pixel yielding a data byte and a
// padding byte holds the next request while both wait, other pixels sustain one per cycle.
// Only the low PIXEL_BITS bits of pixel_color are compared (all eight when PIXEL_BITS >= 8).
module multicolor_pixel_packer #(
	parameter int PIXEL_BITS = mpp_pkg::PIXEL_BITS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] pixel_color,
	input  logic       start_image,
	input  logic       pad_after,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic       status,
	output logic       last
);

	localparam int COLOR_W = (PIXEL_BITS > mpp_pkg::PIXEL_W) ? mpp_pkg::PIXEL_W : PIXEL_BITS;

	logic                       valid_s1;
	logic [COLOR_W-1:0]         color_s1;
	logic                       start_s1;
	logic                       pad_s1;

	mpp_pkg::state_t            state_q;
	mpp_pkg::state_t            state_next;
	logic [COLOR_W-1:0]         table_q [mpp_pkg::NUM_SLOTS];
	logic                       tbl_we;
	logic [mpp_pkg::SLOT_W-1:0] tbl_slot;

	logic [mpp_pkg::CNT_W-1:0]  res_cnt;
	mpp_pkg::result_t           res0;
	mpp_pkg::result_t           res1;
	mpp_pkg::result_t           res0_q;
	mpp_pkg::result_t           res1_q;
	logic [mpp_pkg::CNT_W-1:0]  cnt_q;

	logic out_free;
	logic fire_s1;
	logic in_fire;
	logic out_fire;

	assign out_valid = (cnt_q != '0);
	assign out_fire  = out_valid && out_ready;
	assign out_free  = (cnt_q == '0) || (out_ready && cnt_q == 2'd1);
	assign fire_s1   = valid_s1 && out_free;
	assign in_ready  = !valid_s1 || out_free;
	assign in_fire   = in_valid && in_ready;

	assign data_byte = res0_q.data_byte;
	assign status    = res0_q.status;
	assign last      = res0_q.last;

	mpp_encode #(
		.COLOR_W(COLOR_W)
	) u_encode (
		.color(color_s1),
		.start_image(start_s1),
		.pad_after(pad_s1),
		.state_in(state_q),
		.table_in(table_q),
		.state_next(state_next),
		.tbl_we(tbl_we),
		.tbl_slot(tbl_slot),
		.res_cnt(res_cnt),
		.res0(res0),
		.res1(res1)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			color_s1 <= pixel_color[COLOR_W-1:0];
			start_s1 <= start_image;
			pad_s1   <= pad_after;
		end
	end

	// packing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire_s1) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && tbl_we) begin
			table_q[tbl_slot] <= color_s1;
		end
	end

	// result buffer, up to two bytes per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (fire_s1 && res_cnt != '0) begin
			cnt_q <= res_cnt;
		end else if (out_fire) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && res_cnt != '0) begin
			res0_q <= res0;
			res1_q <= res1;
		end else if (out_fire && cnt_q == 2'd2) begin
			res0_q <= res1_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("result buffer count out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.colors_used <= 3'(mpp_pkg::NUM_SLOTS))
		else $error("more colors recorded than slots");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.overflow_error |-> state_q.colors_used == 3'(mpp_pkg::NUM_SLOTS))
		else $error("overflow flagged with free slots");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == mpp_pkg::STATUS_OVERFLOW) |-> (last && cnt_q == 2'd1))
		else $error("overflow result not a single final result");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && cnt_q == 2'd2) |=> (out_valid && last))
		else $error("second result of a request lost");

endmodule

@@ rtl/core/mpp_encode.sv @@
// color lookup, code assignment and byte packing for one pixel request
module mpp_encode #(
	parameter int COLOR_W = mpp_pkg::PIXEL_BITS_DEFAULT
) (
	input  logic [COLOR_W-1:0]        color,
	input  logic                      start_image,
	input  logic                      pad_after,
	input  mpp_pkg::state_t           state_in,
	input  logic [COLOR_W-1:0]        table_in [mpp_pkg::NUM_SLOTS],
	output mpp_pkg::state_t           state_next,
	output logic                      tbl_we,
	output logic [mpp_pkg::SLOT_W-1:0] tbl_slot,
	output logic [mpp_pkg::CNT_W-1:0] res_cnt,
	output mpp_pkg::result_t          res0,
	output mpp_pkg::result_t          res1
);

	mpp_pkg::state_t eff;
	logic                       hit;
	logic [mpp_pkg::SLOT_W-1:0] hit_slot;
	logic [mpp_pkg::SLOT_W-1:0] slot;
	logic [mpp_pkg::SLOT_W-1:0] code;
	logic                       full;
	mpp_pkg::result_t           pad_res;
	mpp_pkg::result_t           ovf_res;

	// priority match over the used slots
	always_comb begin
		hit      = 1'b0;
		hit_slot = '0;
		for (int i = mpp_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if ((3'(i) < eff.colors_used) && (table_in[i] == color)) begin
				hit      = 1'b1;
				hit_slot = mpp_pkg::SLOT_W'(i);
			end
		end
	end

	always_comb begin
		eff        = start_image ? '0 : state_in;
		full       = (eff.colors_used == 3'(mpp_pkg::NUM_SLOTS));
		pad_res    = '{data_byte: mpp_pkg::PAD_BYTE, status: mpp_pkg::STATUS_DATA, last: 1'b1};
		ovf_res    = '{data_byte: mpp_pkg::PAD_BYTE, status: mpp_pkg::STATUS_OVERFLOW,
			last: 1'b1};
		state_next = eff;
		tbl_we     = 1'b0;
		slot       = hit ? hit_slot : eff.colors_used[mpp_pkg::SLOT_W-1:0];
		tbl_slot   = slot;
		code       = ~slot;
		res_cnt    = '0;
		res0       = '0;
		res1       = '0;
		if (eff.overflow_error) begin
			res_cnt = 2'd1;
			res0    = ovf_res;
		end else if (!hit && full) begin
			state_next.overflow_error = 1'b1;
			res_cnt = 2'd1;
			res0    = ovf_res;
		end else begin
			if (!hit) begin
				tbl_we                 = 1'b1;
				state_next.colors_used = eff.colors_used + 3'd1;
			end
			if (eff.pixel_position == 2'd3) begin
				state_next.partial_byte   = '0;
				state_next.pixel_position = '0;
				res0    = '{data_byte: {eff.partial_byte, code},
					status: mpp_pkg::STATUS_DATA, last: !pad_after};
				res_cnt = 2'd1;
			end else begin
				state_next.partial_byte   = {eff.partial_byte[3:0], code};
				state_next.pixel_position = eff.pixel_position + 2'd1;
			end
			if (pad_after) begin
				if (res_cnt == 2'd0) begin
					res0 = pad_res;
				end else begin
					res1 = pad_res;
				end
				res_cnt = res_cnt + 2'd1;
			end
		end
	end

endmodule
